@@ hdl/cht_pkg.sv @@
// Package for the chained hash table engine: request/status codes, widths,
// FNV-1a constants and the front-to-back work item type. No dependencies.
`default_nettype none
package cht_pkg;
  localparam int HomeSlotsDefault = 256;
  localparam int PoolSlotsDefault = 64;
  localparam int ValueBitsDefault = 64;
  localparam int QueueDepth = 2;

  localparam logic [63:0] FnvOffset = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001B3;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_GET = 2'd2,
    REQ_BAD = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_DUP = 3'd1,
    ST_FOUND = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_REMOVED = 3'd4,
    ST_FULL = 3'd5
  } status_t;

  localparam logic [0:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [0:0] CFG_KEY_BYTES = 1'b1;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_HASH,
    FS_MOD,
    FS_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_HOME_RD,
    BS_HOME_CHK,
    BS_POOL_RD,
    BS_POOL_CHK,
    BS_FREE_RD,
    BS_FREE_WAIT,
    BS_DONE
  } back_state_t;

  // hashed, masked item passed from front to back
  typedef struct packed {
    logic [1:0] req;
    logic [63:0] key;
    logic [63:0] kmask;
    logic [63:0] value;
    logic [16:0] home;
  } work_t;
endpackage
`default_nettype wire

@@ hdl/chained_hash_table_engine.sv @@
// Top level: front hashes and reduces a request while the back end serves the previous one.
// The front takes a new request only when idle; its rate is set by the byte-serial hash and
// the 64-step modulo, and chain walks in the back end or output stalls can hold it further.
// Reset: synchronous; the free stack is filled after reset, and no request is served until then.
`default_nettype none
module chained_hash_table_engine import cht_pkg::*; #(
  parameter int HOME_SLOTS = HomeSlotsDefault,
  parameter int POOL_SLOTS = PoolSlotsDefault,
  parameter int VALUE_BITS = ValueBitsDefault
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] req_type,
  input wire logic [63:0] key,
  input wire logic [63:0] value,
  output logic out_valid,
  input wire logic out_ready,
  output logic [2:0] status,
  output logic [63:0] value_out,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [0:0] cfg_index,
  input wire logic [8:0] cfg_data
);
  logic [8:0] table_size;
  logic [3:0] key_bytes;
  logic push, q_full, pop, q_nempty;
  work_t push_item, head;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= 9'd256;
      key_bytes <= 4'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TABLE_SIZE: table_size <= cfg_data;
        CFG_KEY_BYTES: key_bytes <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  cht_front #(.HOME_SLOTS(HOME_SLOTS), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .key, .value,
    .table_size, .key_bytes, .push, .push_item, .q_full
  );
  cht_queue u_queue (
    .clk, .rst, .push, .push_item, .full(q_full), .pop,
    .not_empty(q_nempty), .head
  );
  cht_back #(.HOME_SLOTS(HOME_SLOTS), .POOL_SLOTS(POOL_SLOTS),
             .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .q_valid(q_nempty), .q_item(head), .pop,
    .out_valid, .out_ready, .status, .value_out
  );
endmodule
`default_nettype wire

@@ hdl/cht_front.sv @@
// Front end: accepts requests, masks key and value, hashes one byte a cycle
// and reduces the hash modulo table size bit serially. Uses cht_pkg.
`default_nettype none
module cht_front import cht_pkg::*; #(
  parameter int HOME_SLOTS = HomeSlotsDefault,
  parameter int VALUE_BITS = ValueBitsDefault
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] req_type,
  input wire logic [63:0] key,
  input wire logic [63:0] value,
  input wire logic [8:0] table_size,
  input wire logic [3:0] key_bytes,
  output logic push,
  output work_t push_item,
  input wire logic q_full
);
  localparam int HW = $clog2(HOME_SLOTS + 1);

  front_state_t state, state_next;
  work_t item;
  logic [63:0] hash;
  logic [3:0] nbytes, bcnt;
  logic [6:0] mcnt;
  logic [HW:0] rem;
  logic [HW-1:0] size;

  logic [3:0] eff_bytes;
  logic [63:0] kmask;
  logic [HW-1:0] eff_size;
  logic [HW:0] rem_sh;

  // FNV prime is 2^40 + 0x1B3: shifts and adds
  function automatic logic [63:0] fnv_mul(input logic [63:0] h);
    return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

  always_comb begin
    if (key_bytes == 4'd0) eff_bytes = 4'd1;
    else if (key_bytes > 4'd8) eff_bytes = 4'd8;
    else eff_bytes = key_bytes;
    kmask = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < eff_bytes) kmask[i*8 +: 8] = 8'hFF;
    end
    if (table_size == 9'd0) eff_size = HW'(1);
    else if (32'(table_size) > HOME_SLOTS) eff_size = HW'(HOME_SLOTS);
    else eff_size = HW'(table_size);
    rem_sh = {rem[HW-1:0], hash[63 - mcnt[5:0]]};
  end

  assign in_ready = (state == FS_IDLE);
  assign push = (state == FS_PUSH) && !q_full;
  always_comb begin
    push_item = item;
    push_item.home = 17'(rem[HW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE: if (in_valid) state_next = FS_HASH;
      FS_HASH: if (bcnt == nbytes) state_next = FS_MOD;
      FS_MOD: if (mcnt == 7'd64) state_next = FS_PUSH;
      FS_PUSH: if (!q_full) state_next = FS_IDLE;
      default: state_next = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      FS_IDLE: begin
        item.req <= req_type;
        item.key <= key & kmask;
        item.kmask <= kmask;
        item.value <= value & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_BITS));
        item.home <= '0;
        nbytes <= eff_bytes;
        size <= eff_size;
        hash <= FnvOffset;
        bcnt <= '0;
        mcnt <= '0;
        rem <= '0;
      end
      FS_HASH: begin
        if (bcnt != nbytes) begin
          hash <= fnv_mul(hash ^ 64'(item.key[bcnt[2:0]*8 +: 8]));
          bcnt <= bcnt + 4'd1;
        end
      end
      FS_MOD: begin
        if (mcnt != 7'd64) begin
          // restoring reduction, one hash bit per cycle
          if (rem_sh >= {1'b0, size}) rem <= rem_sh - {1'b0, size};
          else rem <= rem_sh;
          mcnt <= mcnt + 7'd1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/cht_queue.sv @@
// Short FIFO of hashed work items between front and back end. Uses cht_pkg.
`default_nettype none
module cht_queue import cht_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire work_t push_item,
  output logic full,
  input wire logic pop,
  output logic not_empty,
  output work_t head
);
  work_t buf_q [QueueDepth];
  logic [$clog2(QueueDepth):0] count;
  logic [$clog2(QueueDepth)-1:0] wptr, rptr;

  assign full = (count == ($clog2(QueueDepth)+1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign head = buf_q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_q[wptr] <= push_item;
  end
endmodule
`default_nettype wire

@@ hdl/cht_back.sv @@
// Back end: table memories, chain walk, free stack and result register.
// Uses cht_pkg; fed from cht_queue.
`default_nettype none
module cht_back import cht_pkg::*; #(
  parameter int HOME_SLOTS = HomeSlotsDefault,
  parameter int POOL_SLOTS = PoolSlotsDefault,
  parameter int VALUE_BITS = ValueBitsDefault
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic q_valid,
  input wire work_t q_item,
  output logic pop,
  output logic out_valid,
  input wire logic out_ready,
  output logic [2:0] status,
  output logic [63:0] value_out
);
  localparam int HA = (HOME_SLOTS > 1) ? $clog2(HOME_SLOTS) : 1;
  localparam int PA = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int LW = $clog2(POOL_SLOTS + 1);
  localparam int CW = $clog2(POOL_SLOTS + 1);

  typedef struct packed {
    logic [63:0] key;
    logic [VALUE_BITS-1:0] val;
    logic [LW-1:0] link;
  } entry_t;

  entry_t home_mem [HOME_SLOTS];
  entry_t pool_mem [POOL_SLOTS];
  logic [PA-1:0] free_mem [POOL_SLOTS];
  logic [HOME_SLOTS-1:0] home_valid;
  logic [CW-1:0] free_count;
  logic [CW-1:0] init_cnt;
  logic init_done;

  back_state_t state, state_next;
  work_t w;
  entry_t home_rd, pool_rd, prev_ent;
  logic [PA-1:0] free_rd;
  logic [HA-1:0] home;
  logic [LW-1:0] cur_link, prev_link, fix_link;
  logic [CW-1:0] steps;

  entry_t home_wdata, pool_wdata;
  logic home_we, pool_we, free_we;
  logic [PA-1:0] pool_waddr, pool_raddr, free_waddr, free_wdata;
  logic [CW-1:0] free_count_next;
  logic valid_set, valid_clr;
  logic walk_step, fix_load;
  logic [LW-1:0] fix_value;
  logic res_load;
  logic [2:0] res_status;
  logic [63:0] res_value;

  function automatic logic link_ok(input logic [LW-1:0] l);
    return (l != '0) && (32'(l) <= POOL_SLOTS);
  endfunction

  assign home = w.home[HA-1:0];
  assign pop = (state == BS_IDLE) && q_valid && init_done && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
      home_valid <= '0;
      free_count <= CW'(POOL_SLOTS);
      init_cnt <= '0;
      init_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      free_count <= free_count_next;
      if (valid_set) home_valid[home] <= 1'b1;
      if (valid_clr) home_valid[home] <= 1'b0;
      if (!init_done) begin
        init_cnt <= init_cnt + 1'b1;
        if (init_cnt == CW'(POOL_SLOTS - 1)) init_done <= 1'b1;
      end
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (home_we) home_mem[home] <= home_wdata;
    home_rd <= home_mem[home];
    if (pool_we) pool_mem[pool_waddr] <= pool_wdata;
    pool_rd <= pool_mem[pool_raddr];
    if (!init_done) free_mem[init_cnt[PA-1:0]] <= PA'(POOL_SLOTS - 1) - init_cnt[PA-1:0];
    else if (free_we) free_mem[free_waddr] <= free_wdata;
    free_rd <= free_mem[PA'(free_count - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w <= q_item;
    end
    if (state == BS_HOME_CHK) begin
      cur_link <= home_rd.link;
      prev_link <= '0;
      steps <= '0;
    end
    // advance along the chain, remembering the entry just passed
    if (walk_step) begin
      prev_link <= cur_link;
      prev_ent <= pool_rd;
      cur_link <= pool_rd.link;
      steps <= steps + 1'b1;
    end
    if (fix_load) fix_link <= fix_value;
    if (res_load) begin
      status <= res_status;
      value_out <= res_value;
    end
  end

  assign pool_raddr = PA'(cur_link - 1'b1);

  always_comb begin
    state_next = state;
    home_we = 1'b0;
    home_wdata = home_rd;
    pool_we = 1'b0;
    pool_waddr = PA'(cur_link - 1'b1);
    pool_wdata = pool_rd;
    free_we = 1'b0;
    free_waddr = PA'(free_count);
    free_wdata = PA'(cur_link - 1'b1);
    free_count_next = free_count;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    walk_step = 1'b0;
    fix_load = 1'b0;
    fix_value = '0;
    res_load = 1'b0;
    res_status = ST_NOTFOUND;
    res_value = '0;
    unique case (state)
      BS_IDLE: if (pop) state_next = BS_HOME_RD;
      BS_HOME_RD: state_next = BS_HOME_CHK;
      BS_HOME_CHK: begin
        state_next = BS_DONE;
        res_load = 1'b1;
        if (w.req == REQ_BAD) begin
          res_status = ST_NOTFOUND;
        end else if (!home_valid[home]) begin
          if (w.req == REQ_ADD) begin
            home_we = 1'b1;
            home_wdata = '{key: w.key, val: w.value[VALUE_BITS-1:0], link: '0};
            valid_set = 1'b1;
            res_status = ST_ADDED;
            res_value = w.value;
          end
        end else if ((home_rd.key & w.kmask) == w.key) begin
          if (w.req == REQ_ADD) res_status = ST_DUP;
          else if (w.req == REQ_GET) begin
            res_status = ST_FOUND;
            res_value = 64'(home_rd.val);
          end else begin
            res_status = ST_REMOVED;
            if (link_ok(home_rd.link)) begin
              // pull first chained entry home, then free it
              res_load = 1'b0;
              state_next = BS_POOL_RD;
            end else valid_clr = 1'b1;
          end
        end else if (link_ok(home_rd.link)) begin
          res_load = 1'b0;
          state_next = BS_POOL_RD;
        end else if (w.req == REQ_ADD) begin
          res_load = 1'b0;
          state_next = BS_FREE_RD;
        end
      end
      BS_POOL_RD: state_next = BS_POOL_CHK;
      BS_POOL_CHK: begin
        res_load = 1'b1;
        state_next = BS_DONE;
        if ((w.req == REQ_REMOVE) && ((home_rd.key & w.kmask) == w.key)) begin
          home_we = 1'b1;
          home_wdata = pool_rd;
          if (free_count < CW'(POOL_SLOTS)) begin
            free_we = 1'b1;
            free_count_next = free_count + 1'b1;
          end
          res_status = ST_REMOVED;
        end else if ((pool_rd.key & w.kmask) == w.key) begin
          if (w.req == REQ_ADD) res_status = ST_DUP;
          else if (w.req == REQ_GET) begin
            res_status = ST_FOUND;
            res_value = 64'(pool_rd.val);
          end else begin
            res_status = ST_REMOVED;
            if (prev_link == '0) begin
              home_we = 1'b1;
              home_wdata.link = pool_rd.link;
            end else begin
              res_load = 1'b0;
              state_next = BS_FREE_WAIT;
              fix_load = 1'b1;
              fix_value = pool_rd.link;
            end
            if (free_count < CW'(POOL_SLOTS)) begin
              free_we = 1'b1;
              free_count_next = free_count + 1'b1;
            end
          end
        end else begin
          walk_step = 1'b1;
          if (link_ok(pool_rd.link) && (steps + 1'b1 < CW'(POOL_SLOTS))) begin
            res_load = 1'b0;
            state_next = BS_POOL_RD;
          end else if (w.req == REQ_ADD) begin
            // end of chain: take a pool entry
            res_load = 1'b0;
            state_next = BS_FREE_RD;
          end
        end
      end
      BS_FREE_RD: begin
        // free_rd holds the top of the free stack
        res_load = 1'b1;
        state_next = BS_DONE;
        if (free_count == '0) res_status = ST_FULL;
        else begin
          free_count_next = free_count - 1'b1;
          pool_we = 1'b1;
          pool_waddr = free_rd;
          pool_wdata = '{key: w.key, val: w.value[VALUE_BITS-1:0], link: '0};
          if (prev_link == '0) begin
            home_we = 1'b1;
            home_wdata.link = LW'(free_rd) + 1'b1;
          end else begin
            res_load = 1'b0;
            state_next = BS_FREE_WAIT;
            fix_load = 1'b1;
            fix_value = LW'(free_rd) + 1'b1;
          end
          res_status = ST_ADDED;
          res_value = w.value;
        end
      end
      BS_FREE_WAIT: begin
        // relink the previous pool entry
        pool_we = 1'b1;
        pool_waddr = PA'(prev_link - 1'b1);
        pool_wdata = prev_ent;
        pool_wdata.link = fix_link;
        res_load = 1'b1;
        state_next = BS_DONE;
        if (w.req == REQ_ADD) begin
          res_status = ST_ADDED;
          res_value = w.value;
        end else res_status = ST_REMOVED;
      end
      BS_DONE: if (!out_valid) state_next = BS_IDLE;
      default: state_next = BS_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/cht_checker.sv @@
// Port-level checks for chained_hash_table_engine, bound to the top level.
// Uses cht_pkg status codes.
`default_nettype none
module cht_port_checks import cht_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] status,
  input wire logic [63:0] value_out
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped while stalled");
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL)
    else $error("bad status code");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DUP || status == ST_NOTFOUND ||
                  status == ST_REMOVED || status == ST_FULL) |-> value_out == '0)
    else $error("value_out not zero");
endmodule

bind chained_hash_table_engine cht_port_checks u_chk (
  .clk, .rst, .out_valid, .out_ready, .status, .value_out
);
`default_nettype wire

@@ sim/cht_checker.sv @@
// Checker for the chained hash table engine: watches the request, result and
// register channels, keeps its own copy of the table and compares results.
// Depends on cht_pkg.
`default_nettype none
module cht_checker import cht_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic [1:0] req_type,
  input wire logic [63:0] key,
  input wire logic [63:0] value,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] status,
  input wire logic [63:0] value_out,
  input wire logic cfg_valid,
  input wire logic cfg_ready,
  input wire logic [0:0] cfg_index,
  input wire logic [8:0] cfg_data,
  output int errors,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Homes = 256;
  localparam int Pool = 64;

  typedef struct packed {
    status_t st;
    logic [63:0] val;
  } outcome_t;

  outcome_t expected_q[$];

  logic [8:0] tbl_size;
  logic [3:0] kbytes;
  bit h_used[Homes];
  logic [63:0] h_key[Homes], h_val[Homes];
  int h_next[Homes];
  logic [63:0] p_key[Pool], p_val[Pool];
  int p_next[Pool];
  int free_stack[Pool];
  int free_n;

  assign pending = expected_q.size();

  task automatic report(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic logic [63:0] fnv_hash(input logic [63:0] k, input int nb);
    logic [63:0] h;
    h = FnvOffset;
    for (int i = 0; i < nb; i++) begin
      h = h ^ {56'd0, k[8*i +: 8]};
      h = h * FnvPrime;
    end
    return h;
  endfunction

  function automatic int link_to_idx(input int lnk);
    return (lnk == 0 || lnk > Pool) ? -1 : lnk - 1;
  endfunction

  function automatic void release_slot(input int idx);
    if (free_n < Pool) begin
      free_stack[free_n] = idx;
      free_n++;
    end
  endfunction

  function automatic outcome_t table_access(input req_t rq, input logic [63:0] k_in,
                                            input logic [63:0] v);
    int nb, sz, home, prv, cur, steps, slot;
    logic [63:0] km, k;
    outcome_t r;
    nb = (kbytes == 0) ? 1 : (kbytes > 8) ? 8 : int'(kbytes);
    sz = (tbl_size == 0) ? 1 : (tbl_size > Homes) ? Homes : int'(tbl_size);
    km = (nb >= 8) ? '1 : ((64'd1 << (8 * nb)) - 64'd1);
    k = k_in & km;
    home = int'(fnv_hash(k, nb) % 64'(sz));
    r.st = ST_NOTFOUND;
    r.val = '0;
    if (rq == REQ_BAD) return r;
    if (!h_used[home]) begin
      if (rq == REQ_ADD) begin
        h_used[home] = 1;
        h_key[home] = k;
        h_val[home] = v;
        h_next[home] = 0;
        r.st = ST_ADDED;
        r.val = v;
      end
    end else if ((h_key[home] & km) == k) begin
      if (rq == REQ_ADD) r.st = ST_DUP;
      else if (rq == REQ_GET) begin
        r.st = ST_FOUND;
        r.val = h_val[home];
      end else begin
        cur = link_to_idx(h_next[home]);
        if (cur >= 0) begin
          // pull the first chained entry into the home slot
          h_key[home] = p_key[cur];
          h_val[home] = p_val[cur];
          h_next[home] = p_next[cur];
          release_slot(cur);
        end else h_used[home] = 0;
        r.st = ST_REMOVED;
      end
    end else begin
      prv = -1;
      cur = link_to_idx(h_next[home]);
      steps = 0;
      while (cur >= 0 && steps < Pool) begin
        if ((p_key[cur] & km) == k) break;
        prv = cur;
        cur = link_to_idx(p_next[cur]);
        steps++;
      end
      if (cur >= 0 && steps < Pool) begin
        if (rq == REQ_ADD) r.st = ST_DUP;
        else if (rq == REQ_GET) begin
          r.st = ST_FOUND;
          r.val = p_val[cur];
        end else begin
          if (prv < 0) h_next[home] = p_next[cur];
          else p_next[prv] = p_next[cur];
          release_slot(cur);
          r.st = ST_REMOVED;
        end
      end else if (rq == REQ_ADD) begin
        if (free_n == 0) r.st = ST_FULL;
        else begin
          free_n--;
          slot = free_stack[free_n] % Pool;
          p_key[slot] = k;
          p_val[slot] = v;
          p_next[slot] = 0;
          if (prv < 0) h_next[home] = slot + 1;
          else p_next[prv] = slot + 1;
          r.st = ST_ADDED;
          r.val = v;
        end
      end
    end
    return r;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      tbl_size <= 9'd256;
      kbytes <= 4'd8;
      for (int i = 0; i < Homes; i++) h_used[i] = 0;
      for (int i = 0; i < Pool; i++) free_stack[i] = Pool - 1 - i;
      free_n = Pool;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TABLE_SIZE) tbl_size <= cfg_data;
        else kbytes <= cfg_data[3:0];
      end
      if (in_valid && in_ready)
        expected_q.push_back(table_access(req_t'(req_type), key, value));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) report("result with no request outstanding");
        else begin
          e = expected_q.pop_front();
          if (status !== e.st)
            report($sformatf("status %0d, expected %0d", status, e.st));
          if (value_out !== e.val)
            report($sformatf("value_out %h, expected %h", value_out, e.val));
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ sim/chained_hash_table_engine_tb.sv @@
// Testbench top for the chained hash table engine: clock, reset, register
// writes and request stimulus under several idle patterns; cht_checker judges.
// Depends on cht_pkg, cht_checker and the engine RTL.
`default_nettype none
module chained_hash_table_engine_tb import cht_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic [1:0] req_type = REQ_GET;
  logic [63:0] key = '0, value = '0;
  logic [0:0] cfg_index = CFG_TABLE_SIZE;
  logic [8:0] cfg_data = '0;
  logic in_ready, out_valid, cfg_ready;
  logic [2:0] status;
  logic [63:0] value_out;
  int errors, pending;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int quiet_cycles = 0;
  logic [63:0] key_pool[16];

  always #5 clk = ~clk;

  chained_hash_table_engine dut (
    .clk, .rst, .in_valid, .in_ready, .req_type, .key, .value,
    .out_valid, .out_ready, .status, .value_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  cht_checker chk (
    .clk, .rst, .in_valid, .in_ready, .req_type, .key, .value,
    .out_valid, .out_ready, .status, .value_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  // returns at the accepting edge; a later step drops valid
  task automatic send_request(input req_t rq, input logic [63:0] k, input logic [63:0] v);
    @(negedge clk);
    cfg_valid <= 0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    req_type <= rq;
    key <= k;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [8:0] data);
    @(negedge clk);
    in_valid <= 0;
    cfg_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // mostly keys from a small set so adds, hits and removes collide
  task automatic random_requests(input int n);
    logic [63:0] k;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      k = (pick < 8) ? key_pool[$urandom_range(15)] : {$urandom, $urandom};
      pick = $urandom_range(19);
      send_request(pick < 9 ? REQ_ADD : pick < 14 ? REQ_GET : pick < 19 ? REQ_REMOVE
                   : REQ_BAD, k, {$urandom, $urandom});
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(negedge clk);
    rst <= 0;
    // directed: extremes, every request, chains, duplicate and bad type
    write_reg(CFG_TABLE_SIZE, 9'd1);
    write_reg(CFG_KEY_BYTES, 9'd8);
    send_request(REQ_GET, '0, '0);
    send_request(REQ_ADD, '0, '1);
    send_request(REQ_ADD, '0, 64'd5);
    send_request(REQ_ADD, '1, '0);
    send_request(REQ_ADD, 64'd7, 64'h1234);
    send_request(REQ_GET, '1, '0);
    send_request(REQ_GET, 64'd9, '0);
    send_request(REQ_REMOVE, '1, '0);
    send_request(REQ_REMOVE, '0, '0);
    send_request(REQ_GET, 64'd7, '0);
    send_request(REQ_BAD, 64'd7, '1);
    send_request(REQ_REMOVE, 64'd7, '0);
    send_request(REQ_REMOVE, 64'd7, '0);
    // fill the pool through one chain to reach pool full
    for (int i = 0; i < 66; i++) send_request(REQ_ADD, 64'(i + 100), 64'(i));
    send_request(REQ_GET, 64'd150, '0);
    write_reg(CFG_KEY_BYTES, 9'd1);
    send_request(REQ_GET, 64'hFF00_0000_0000_0064, '0);
    write_reg(CFG_TABLE_SIZE, 9'd0);
    write_reg(CFG_KEY_BYTES, 9'd0);
    send_request(REQ_ADD, 64'hABCD, 64'd3);
    write_reg(CFG_TABLE_SIZE, 9'd511);
    write_reg(CFG_KEY_BYTES, 9'd15);
    send_request(REQ_GET, 64'h5, '0);

    // random phases over settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_TABLE_SIZE, ph == 0 ? 9'd256 : ph == 1 ? 9'd1 : 9'($urandom_range(1, 300)));
      write_reg(CFG_KEY_BYTES, ph == 2 ? 9'd1 : ph == 3 ? 9'd8 : 9'($urandom_range(0, 9)));
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 79; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 79; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      random_requests(155);
    end

    @(negedge clk);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
